>>> hw/rtl/pst_pkg.sv
package pst_pkg;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int NAME_BYTES_DEF = 8;

  localparam int KIND_W   = 2;
  localparam int KEY_IN_W = 64;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int US_W     = 16;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 5;
  localparam int N_W      = 5;

  // period, last run, run count and longest duration beside the key
  localparam int ENTRY_FIX_W = 3 * TIME_W + US_W;

  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 64;

  localparam logic [N_W-1:0] RES_CAP = 5'd16;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_PAR = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_TASK = 2'd3;

  typedef struct packed {
    logic              last;
    logic [CNT_W-1:0]  count;
    logic [US_W-1:0]   longest;
    logic [TIME_W-1:0] runs;
    logic              due;
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] status;
  } res_t;

  function automatic res_t mk_res(input logic [STAT_W-1:0] status,
                                  input logic [SLOT_W-1:0] slot,
                                  input logic              due,
                                  input logic [TIME_W-1:0] runs,
                                  input logic [US_W-1:0]   longest,
                                  input logic [CNT_W-1:0]  count,
                                  input logic              last);
    res_t r;
    r.status  = status;
    r.slot    = slot;
    r.due     = due;
    r.runs    = runs;
    r.longest = longest;
    r.count   = count;
    r.last    = last;
    return r;
  endfunction

endpackage

>>> hw/rtl/periodic_task_scheduler_table_top.sv
// Periodic task table. Each input transaction is an add (kind 0), a tick scan
// (kind 1) or a run-duration report (kind 2); other kinds are taken and dropped.
// The table lives in one synchronous memory, one entry per task, and every
// transaction is served by a sequencer that reads one entry per cycle unless
// stalled, and writes back the entries it updates. An add searches the used
// entries until the key matches; a tick scans the used entries and gives up
// to sixteen results with tlast on the final one; a report updates one slot.
// One new transaction is accepted once the previous one has placed its last
// result in the output register, so a result may wait there while the next
// transaction is already under way. Output backpressure stalls the scan only
// when a further result is ready to leave.
module periodic_task_scheduler_table_top #(
  parameter int MAX_TASKS  = pst_pkg::MAX_TASKS_DEF,
  parameter int NAME_BYTES = pst_pkg::NAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [63:0] name_key, [95:64] period, [127:96] now_ms, [131:128] task_slot,
  // [147:132] start_us, [163:148] end_us, rest zero
  input  logic [pst_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [pst_pkg::KIND_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [5:2] slot_index, [6] due, [38:7] runs, [54:39] longest_us,
  // [59:55] task_count, rest zero
  output logic [pst_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import pst_pkg::*;

  localparam int KEY_W = 8 * NAME_BYTES;
  localparam int DW    = KEY_W + ENTRY_FIX_W;
  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic          out_free, push, wr_en;
  res_t          res;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] rd_data, wr_data;

  pst_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pst_seq #(
    .MAX_TASKS  (MAX_TASKS),
    .NAME_BYTES (NAME_BYTES)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_kind      (in_tuser),
    .in_name_key  (in_tdata[63:0]),
    .in_period    (in_tdata[95:64]),
    .in_now_ms    (in_tdata[127:96]),
    .in_task_slot (in_tdata[131:128]),
    .in_start_us  (in_tdata[147:132]),
    .in_end_us    (in_tdata[163:148]),
    .out_free     (out_free),
    .push         (push),
    .res          (res),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  pst_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_free   (out_free)
  );

endmodule

>>> hw/rtl/pst_mem.sv
module pst_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 176
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/pst_seq.sv
module pst_seq #(
  parameter int MAX_TASKS  = 16,
  parameter int NAME_BYTES = 8,
  localparam int KEY_W = 8 * NAME_BYTES,
  localparam int DW    = KEY_W + pst_pkg::ENTRY_FIX_W,
  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int CW    = $clog2(MAX_TASKS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pst_pkg::KIND_W-1:0]    in_kind,
  input  logic [pst_pkg::KEY_IN_W-1:0]  in_name_key,
  input  logic [pst_pkg::TIME_W-1:0]    in_period,
  input  logic [pst_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [pst_pkg::SLOT_W-1:0]    in_task_slot,
  input  logic [pst_pkg::US_W-1:0]      in_start_us,
  input  logic [pst_pkg::US_W-1:0]      in_end_us,
  input  logic                          out_free,
  output logic                          push,
  output pst_pkg::res_t                 res,
  output logic [AW-1:0]                 rd_addr,
  input  logic [DW-1:0]                 rd_data,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [DW-1:0]                 wr_data
);
  import pst_pkg::*;

  localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_REP  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  res_t              held_r, held_nxt;
  logic              held_v_r, held_v_nxt;

  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] period_r;
  logic [TIME_W-1:0] now_r;
  logic [SLOT_W-1:0] slot_r;
  logic [US_W-1:0]   dt_r;
  logic              slot_ok_r;

  logic [KEY_W-1:0]  e_key;
  logic [TIME_W-1:0] e_period, e_last, e_runs, e_runs_inc;
  logic [US_W-1:0]   e_long, new_long;
  logic              accept, idx_lt, match, due_hit;
  logic [SLOT_W-1:0] idx_slot;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign e_key      = rd_data[DW-1 -: KEY_W];
  assign e_period   = rd_data[3*TIME_W+US_W-1 -: TIME_W];
  assign e_last     = rd_data[2*TIME_W+US_W-1 -: TIME_W];
  assign e_runs     = rd_data[TIME_W+US_W-1 -: TIME_W];
  assign e_long     = rd_data[US_W-1:0];
  assign e_runs_inc = e_runs + 32'd1;
  assign new_long   = (dt_r > e_long) ? dt_r : e_long;

  assign idx_lt   = idx_r < used_r;
  assign match    = (e_key == key_r);
  assign due_hit  = (now_r - e_last) >= e_period;
  assign idx_slot = SLOT_W'(idx_r);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    used_nxt   = used_r;
    n_nxt      = n_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    push       = 1'b0;
    res        = '0;
    wr_en      = 1'b0;
    wr_addr    = idx_r[AW-1:0];
    wr_data    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          n_nxt   = '0;
          case (in_kind)
            KIND_ADD:    state_nxt = S_ADD;
            KIND_TICK:   state_nxt = S_TICK;
            KIND_REPORT: state_nxt = S_REP;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (period_r == '0) begin
          if (out_free) begin
            push      = 1'b1;
            res       = mk_res(ST_BAD_PAR, '0, 1'b0, '0, '0, CNT_W'(used_r), 1'b1);
            state_nxt = S_IDLE;
          end
        end else if (idx_lt && !match) begin
          idx_nxt = idx_r + 1'b1;
        end else if (idx_lt) begin
          if (out_free) begin
            wr_en     = 1'b1;
            wr_data   = {key_r, period_r, now_r, 32'd0, 16'd0};
            push      = 1'b1;
            res       = mk_res(ST_OK, idx_slot, 1'b0, '0, '0, CNT_W'(used_r), 1'b1);
            state_nxt = S_IDLE;
          end
        end else if (out_free) begin
          // key not present: append, or refuse when the table is full
          push      = 1'b1;
          state_nxt = S_IDLE;
          if (used_r == CW'(MAX_TASKS)) begin
            res = mk_res(ST_FULL, '0, 1'b0, '0, '0, CNT_W'(used_r), 1'b1);
          end else begin
            wr_en    = 1'b1;
            wr_addr  = used_r[AW-1:0];
            wr_data  = {key_r, period_r, now_r, 32'd0, 16'd0};
            used_nxt = used_r + 1'b1;
            res      = mk_res(ST_OK, SLOT_W'(used_r), 1'b0, '0, '0,
                              CNT_W'(used_nxt), 1'b1);
          end
        end
      end
      S_TICK: begin
        if (idx_lt && n_r != RES_CAP) begin
          if (!due_hit) begin
            idx_nxt = idx_r + 1'b1;
          end else if (!held_v_r || out_free) begin
            // hold the newest due result until the scan shows whether it is last
            wr_en      = 1'b1;
            wr_data    = {e_key, e_period, now_r, e_runs_inc, e_long};
            push       = held_v_r;
            res        = held_r;
            held_nxt   = mk_res(ST_OK, idx_slot, 1'b1, e_runs_inc, e_long,
                                CNT_W'(used_r), 1'b0);
            held_v_nxt = 1'b1;
            n_nxt      = n_r + 1'b1;
            idx_nxt    = idx_r + 1'b1;
          end
        end else if (out_free) begin
          push       = 1'b1;
          res        = held_v_r ? held_r
                                : mk_res(ST_OK, '0, 1'b0, '0, '0, CNT_W'(used_r), 1'b0);
          res.last   = 1'b1;
          held_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      S_REP: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
          if (!slot_ok_r) begin
            res = mk_res(ST_NO_TASK, slot_r, 1'b0, '0, '0, CNT_W'(used_r), 1'b1);
          end else begin
            wr_en   = 1'b1;
            wr_addr = AW'(slot_r);
            wr_data = {e_key, e_period, e_last, e_runs, new_long};
            res     = mk_res(ST_OK, slot_r, 1'b0, e_runs, new_long, CNT_W'(used_r), 1'b1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Stalled scans re-read the current entry; advancing scans fetch the next one.
  // A stalled report keeps reading its own slot.
  assign rd_addr = (state_r == S_IDLE && in_kind == KIND_REPORT) ? AW'(in_task_slot) :
                   (state_r == S_REP)                            ? AW'(slot_r)
                                                                 : idx_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      idx_r    <= '0;
      n_r      <= '0;
      held_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      idx_r    <= idx_nxt;
      n_r      <= n_nxt;
      held_v_r <= held_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (accept) begin
      key_r     <= in_name_key[KEY_W-1:0];
      period_r  <= in_period;
      now_r     <= in_now_ms;
      slot_r    <= in_task_slot;
      dt_r      <= in_end_us - in_start_us;
      slot_ok_r <= CMPW'(in_task_slot) < CMPW'(used_r);
    end
  end

  a_held_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r |-> state_r == S_TICK)
    else $error("held tick result outside a scan");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into a full output register");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_TASKS))
    else $error("task count beyond table depth");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r != S_IDLE)
    else $error("table write while idle");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RES_CAP)
    else $error("tick produced more results than allowed");

endmodule

>>> hw/rtl/pst_out.sv
module pst_out (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  pst_pkg::res_t                     res,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [pst_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  output logic                              out_free
);
  import pst_pkg::*;

  logic valid_r;
  res_t res_r;

  assign out_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {4'd0, res_r.count, res_r.longest, res_r.runs,
                       res_r.due, res_r.slot, res_r.status};

endmodule

>>> sim/task_table_checker.sv
module task_table_checker #(
  parameter int MAX_TASKS  = pst_pkg::MAX_TASKS_DEF,
  parameter int NAME_BYTES = pst_pkg::NAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [pst_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [pst_pkg::KIND_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [pst_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  output int                              mismatches,
  output int                              outstanding,
  output int                              results_checked,
  output int                              due_results,
  output int                              error_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  // shadow copy of the task table
  logic [KEY_IN_W-1:0] task_key     [MAX_TASKS];
  logic [TIME_W-1:0]   task_period  [MAX_TASKS];
  logic [TIME_W-1:0]   task_last_ms [MAX_TASKS];
  logic [TIME_W-1:0]   task_runs    [MAX_TASKS];
  logic [US_W-1:0]     task_longest [MAX_TASKS];
  int                  tasks_used;

  res_t table_results[$];
  res_t seen;
  res_t want;

  task automatic queue_result(input logic [STAT_W-1:0] status, input int slot,
                              input logic due, input logic [TIME_W-1:0] runs,
                              input logic [US_W-1:0] longest, input logic last);
    res_t r;
    r         = '0;
    r.status  = status;
    r.slot    = slot[SLOT_W-1:0];
    r.due     = due;
    r.runs    = runs;
    r.longest = longest;
    r.count   = tasks_used[CNT_W-1:0];
    r.last    = last;
    table_results.push_back(r);
  endtask

  task automatic update_task_table(input logic [KIND_W-1:0] kind,
                                   input logic [IN_TDATA_W-1:0] d);
    logic [KEY_IN_W-1:0] key;
    logic [TIME_W-1:0]   period;
    logic [TIME_W-1:0]   now_ms;
    logic [SLOT_W-1:0]   slot;
    logic [US_W-1:0]     run_us;
    int                  hit;
    int                  n;
    int                  i;
    key    = d[63:0];
    if (NAME_BYTES < 8) key &= (64'd1 << (8 * NAME_BYTES)) - 64'd1;
    period = d[95:64];
    now_ms = d[127:96];
    slot   = d[131:128];
    run_us = d[163:148] - d[147:132];
    case (kind)
      KIND_ADD: begin
        hit = -1;
        if (period == '0) begin
          queue_result(ST_BAD_PAR, 0, 1'b0, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < tasks_used; i++)
            if (hit < 0 && task_key[i] == key) hit = i;
          if (hit < 0 && tasks_used >= MAX_TASKS) begin
            queue_result(ST_FULL, 0, 1'b0, '0, '0, 1'b1);
          end else begin
            if (hit < 0) begin
              hit = tasks_used;
              tasks_used++;
              task_key[hit] = key;
            end
            task_period[hit]  = period;
            task_last_ms[hit] = now_ms;
            task_runs[hit]    = '0;
            task_longest[hit] = '0;
            queue_result(ST_OK, hit, 1'b0, '0, '0, 1'b1);
          end
        end
      end
      KIND_TICK: begin
        n = 0;
        for (i = 0; i < tasks_used && n < int'(RES_CAP); i++) begin
          if (TIME_W'(now_ms - task_last_ms[i]) >= task_period[i]) begin
            task_last_ms[i] = now_ms;
            task_runs[i]    = task_runs[i] + 1;
            queue_result(ST_OK, i, 1'b1, task_runs[i], task_longest[i], 1'b0);
            n++;
          end
        end
        if (n == 0) queue_result(ST_OK, 0, 1'b0, '0, '0, 1'b1);
        else table_results[table_results.size() - 1].last = 1'b1;
      end
      KIND_REPORT: begin
        if (int'(slot) >= tasks_used) begin
          queue_result(ST_NO_TASK, int'(slot), 1'b0, '0, '0, 1'b1);
        end else begin
          if (run_us > task_longest[slot]) task_longest[slot] = run_us;
          queue_result(ST_OK, int'(slot), 1'b0, task_runs[slot], task_longest[slot], 1'b1);
        end
      end
      default: ;  // unknown kind: no result
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tasks_used = 0;
      table_results.delete();
      mismatches      <= 0;
      results_checked <= 0;
      due_results     <= 0;
      error_results   <= 0;
    end else begin
      // compare before predicting, so a stray result is never matched to a new item
      if (out_tvalid && out_tready) begin
        seen = res_t'({out_tlast, out_tdata[$bits(res_t)-2:0]});
        results_checked <= results_checked + 1;
        if (table_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result status=%0d slot=%0d due=%0b runs=%0d",
                     $realtime, seen.status, seen.slot, seen.due, seen.runs);
          mismatches <= mismatches + 1;
        end else begin
          want = table_results.pop_front();
          if (seen.status !== want.status || seen.slot !== want.slot ||
              seen.due !== want.due || seen.runs !== want.runs ||
              seen.longest !== want.longest || seen.count !== want.count ||
              seen.last !== want.last) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch (status slot due runs longest count last)",
                       $realtime);
              $display("  expected %0d %0d %0b %h %h %0d %0b", want.status, want.slot,
                       want.due, want.runs, want.longest, want.count, want.last);
              $display("  actual   %0d %0d %0b %h %h %0d %0b", seen.status, seen.slot,
                       seen.due, seen.runs, seen.longest, seen.count, seen.last);
            end
            mismatches <= mismatches + 1;
          end
          if (want.due) due_results <= due_results + 1;
          if (want.status != ST_OK) error_results <= error_results + 1;
        end
      end
      if (in_tvalid && in_tready) update_task_table(in_tuser, in_tdata);
    end
    outstanding <= table_results.size();
  end

endmodule

>>> sim/periodic_task_scheduler_table_top_tb.sv
module periodic_task_scheduler_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  localparam int MAX_TASKS  = MAX_TASKS_DEF;
  localparam int NAME_BYTES = NAME_BYTES_DEF;
  localparam int RUN_LIMIT  = 1000000;
  localparam int KEY_POOL   = 20;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  int mismatches;
  int outstanding;
  int results_checked;
  int due_results;
  int error_results;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_request;
  int cycle_count;
  int n_add;
  int n_tick;
  int n_report;
  int n_ignored;

  logic [KEY_IN_W-1:0] key_pool [KEY_POOL];
  logic [TIME_W-1:0]   clock_ms;

  periodic_task_scheduler_table_top #(
    .MAX_TASKS (MAX_TASKS),
    .NAME_BYTES(NAME_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  task_table_checker #(
    .MAX_TASKS (MAX_TASKS),
    .NAME_BYTES(NAME_BYTES)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .due_results    (due_results),
    .error_results  (error_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request > 0 && !hold_taken) begin
        hold_left  = hold_off_request;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_IN_W-1:0] key,
                           input logic [TIME_W-1:0] period, input logic [TIME_W-1:0] now_ms,
                           input logic [SLOT_W-1:0] slot, input logic [US_W-1:0] start_us,
                           input logic [US_W-1:0] end_us);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, end_us, start_us, slot, now_ms, period, key};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    case (kind)
      KIND_ADD:    n_add++;
      KIND_TICK:   n_tick++;
      KIND_REPORT: n_report++;
      default:     n_ignored++;
    endcase
  endtask

  task automatic send_random_item();
    int                  pick;
    int                  sub;
    logic [KEY_IN_W-1:0] key;
    logic [TIME_W-1:0]   period;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    key  = {$urandom, $urandom};
    if (pick < 35) begin
      if (sub < 90) key = key_pool[$urandom_range(KEY_POOL - 1)];
      sub = $urandom_range(99);
      if (sub < 8) period = '0;
      else if (sub < 85) period = $urandom_range(1, 40);
      else period = $urandom;
      send_item(KIND_ADD, key, period, clock_ms, SLOT_W'($urandom), US_W'($urandom),
                US_W'($urandom));
    end else if (pick < 70) begin
      // advance time mostly in small steps, with an occasional jump anywhere
      if (sub < 5) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 25);
      send_item(KIND_TICK, key, $urandom, clock_ms, SLOT_W'($urandom), US_W'($urandom),
                US_W'($urandom));
    end else if (pick < 95) begin
      send_item(KIND_REPORT, key, $urandom, $urandom, SLOT_W'($urandom), US_W'($urandom),
                US_W'($urandom));
    end else begin
      send_item(KIND_UNUSED, key, $urandom, $urandom, SLOT_W'($urandom), US_W'($urandom),
                US_W'($urandom));
    end
  endtask

  task automatic run_random(input int n_items);
    int target;
    target = n_add + n_tick + n_report + n_items;
    while (n_add + n_tick + n_report < target) send_random_item();
  endtask

  initial begin
    int i;
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = KIND_ADD;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_request = 0;
    n_add            = 0;
    n_tick           = 0;
    n_report         = 0;
    n_ignored        = 0;
    clock_ms         = $urandom;
    for (i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, bad period, time and duration wrap, update, unknown kind
    send_item(KIND_REPORT, '0, '0, '0, 4'd0, 16'h0000, 16'h0000);
    send_item(KIND_TICK, '0, '0, 32'd0, '0, '0, '0);
    send_item(KIND_ADD, '1, 32'd0, 32'd0, '1, '1, '1);
    send_item(KIND_ADD, '0, 32'd1, 32'd0, '0, '0, '0);
    send_item(KIND_ADD, '1, '1, '1, '1, '1, '1);
    send_item(KIND_TICK, '0, '0, 32'd1, '0, '0, '0);
    send_item(KIND_REPORT, '0, '0, '0, 4'd0, 16'hFFFF, 16'h0000);
    send_item(KIND_REPORT, '0, '0, '0, 4'd1, 16'h0000, 16'hFFFF);
    send_item(KIND_REPORT, '0, '0, '0, 4'd1, 16'h0005, 16'h0005);
    send_item(KIND_REPORT, '1, '1, '1, 4'd15, 16'hFFFF, 16'hFFFF);
    send_item(KIND_UNUSED, '1, '1, '1, '1, '1, '1);
    send_item(KIND_ADD, '0, 32'd5, 32'd1, '0, '0, '0);
    send_item(KIND_TICK, '0, '0, 32'hFFFF_FFFE, '0, '0, '0);
    send_item(KIND_TICK, '0, '0, 32'hFFFF_FFFE, '0, '0, '0);
    send_item(KIND_ADD, '0, '1, 32'd0, '0, '0, '0);
    send_item(KIND_TICK, '0, '0, 32'hFFFF_FFFF, '0, '0, '0);

    // no idling, then a long output hold-off while items keep coming
    run_random(110);
    hold_off_request = 400;
    run_random(20);
    send_idle_pct  = 47;
    recv_stall_pct = 0;
    run_random(120);
    send_idle_pct  = 0;
    recv_stall_pct = 47;
    run_random(120);
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    run_random(120);
    in_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (MAX_TASKS * 4) @(negedge clk);

    $display("Sent %0d adds, %0d ticks, %0d reports and %0d unknown-kind items.",
             n_add, n_tick, n_report, n_ignored);
    $display("Compared %0d results: %0d due-task results, %0d error statuses.",
             results_checked, due_results, error_results);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pst_pkg.sv
hw/rtl/pst_mem.sv
hw/rtl/pst_seq.sv
hw/rtl/pst_out.sv
hw/rtl/periodic_task_scheduler_table_top.sv
sim/task_table_checker.sv
sim/periodic_task_scheduler_table_top_tb.sv
